>>> rtl/iira_pkg.sv
// Package for the indexed insert/remove array core.
// Holds the item and result structs, operation codes and sequencer states.
// No dependencies.
package iira_pkg;

  localparam int KIND_W    = 3;
  localparam int POS_W     = 7;
  localparam int VAL_W     = 32;
  localparam int CNT_OUT_W = 7;

  typedef enum logic [KIND_W-1:0] {
    KIND_GET    = 3'd0,
    KIND_SET    = 3'd1,
    KIND_PUSH   = 3'd2,
    KIND_POP    = 3'd3,
    KIND_INSERT = 3'd4,
    KIND_REMOVE = 3'd5,
    KIND_CLEAR  = 3'd6
  } kind_e;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_EXEC,
    ST_RDATA,
    ST_SHUP,
    ST_INS_FIN,
    ST_RMV_GET,
    ST_SHDN,
    ST_RMV_FIN
  } state_e;

  typedef struct packed {
    logic [KIND_W-1:0] kind;
    logic [POS_W-1:0]  position;
    logic [VAL_W-1:0]  value_in;
  } req_t;

  typedef struct packed {
    logic                 status;
    logic [VAL_W-1:0]     value_out;
    logic [CNT_OUT_W-1:0] count;
  } rsp_t;

endpackage

>>> rtl/indexed_insert_remove_array_core.sv
// Top level of the indexed insert/remove array.
// Instantiates iira_ctrl, iira_step and iira_mem; uses iira_pkg.
//
// Usage:
//   Drive req_i and raise start; the item is taken at a clock edge where
//   start is high and busy is low. busy stays high while the item runs.
//   Each item yields exactly one result on rsp_o, shown for one cycle with
//   done_o high. The receiver cannot stall; a result not taken is lost.
//   Set, push, clear and every error are answered from the execute state,
//   get and pop from the read-data state after it, and insert and remove
//   after any shift states and a finish state. busy falls in the result
//   cycle, so the next item may start then; no new item is taken while one
//   runs. Insert and remove move one element per cycle through the single
//   write and single read port of the store, with one shared step unit
//   advancing the shift pointer each cycle.
//   Reset clears the live count to zero and the sequencer to idle; the
//   element words are not cleared and no clearing pass runs.
module indexed_insert_remove_array_core #(
  parameter int CAPACITY      = 64,
  parameter int ELEMENT_WIDTH = 32
) (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           start,
  output logic           busy,
  input  iira_pkg::req_t req_i,
  output logic           done_o,
  output iira_pkg::rsp_t rsp_o
);

  localparam int AW = $clog2(CAPACITY);
  localparam int CW = $clog2(CAPACITY + 1);

  logic                     mem_we;
  logic [AW-1:0]            mem_waddr;
  logic [ELEMENT_WIDTH-1:0] mem_wdata;
  logic                     mem_re;
  logic [AW-1:0]            mem_raddr;
  logic [ELEMENT_WIDTH-1:0] mem_rdata;
  logic [CW-1:0]            step_a;
  logic [CW-1:0]            step_b;
  logic                     step_dec;
  logic [CW-1:0]            step_res;
  logic                     step_eq;
  logic                     step_hit;

  // sequencer
  iira_ctrl #(
    .CAPACITY      (CAPACITY),
    .ELEMENT_WIDTH (ELEMENT_WIDTH)
  ) u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .start_i     (start),
    .busy_o      (busy),
    .req_i       (req_i),
    .done_o      (done_o),
    .rsp_o       (rsp_o),
    .mem_we_o    (mem_we),
    .mem_waddr_o (mem_waddr),
    .mem_wdata_o (mem_wdata),
    .mem_re_o    (mem_re),
    .mem_raddr_o (mem_raddr),
    .mem_rdata_i (mem_rdata),
    .step_a_o    (step_a),
    .step_b_o    (step_b),
    .step_dec_o  (step_dec),
    .step_res_i  (step_res),
    .step_eq_i   (step_eq),
    .step_hit_i  (step_hit)
  );

  // shared pointer and count step unit
  iira_step #(
    .W (CW)
  ) u_step (
    .a_i   (step_a),
    .b_i   (step_b),
    .dec_i (step_dec),
    .res_o (step_res),
    .eq_o  (step_eq),
    .hit_o (step_hit)
  );

  // element store
  iira_mem #(
    .DEPTH (CAPACITY),
    .WIDTH (ELEMENT_WIDTH)
  ) u_mem (
    .clk_i   (clk_i),
    .we_i    (mem_we),
    .waddr_i (mem_waddr),
    .wdata_i (mem_wdata),
    .re_i    (mem_re),
    .raddr_i (mem_raddr),
    .rdata_o (mem_rdata)
  );

endmodule

>>> rtl/iira_mem.sv
// Element store: one write port, one read port with registered read data.
// No package dependencies.
module iira_mem #(
  parameter int DEPTH = 64,
  parameter int WIDTH = 32,
  localparam int AW   = $clog2(DEPTH)
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AW-1:0]    waddr_i,
  input  logic [WIDTH-1:0] wdata_i,
  input  logic             re_i,
  input  logic [AW-1:0]    raddr_i,
  output logic [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  // write and read the array, read data registered
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

>>> rtl/iira_step.sv
// Shared step unit: increments or decrements a pointer or count and compares.
// No package dependencies.
module iira_step #(
  parameter int W = 7
) (
  input  logic [W-1:0] a_i,
  input  logic [W-1:0] b_i,
  input  logic         dec_i,
  output logic [W-1:0] res_o,
  output logic         eq_o,
  output logic         hit_o
);

  // step by one in the chosen direction
  assign res_o = dec_i ? (a_i - W'(1)) : (a_i + W'(1));
  // compare the stepped value and the operand itself against the bound
  assign eq_o  = (res_o == b_i);
  assign hit_o = (a_i == b_i);

endmodule

>>> rtl/iira_ctrl.sv
// Sequencer for the indexed insert/remove array: decodes an item, drives the
// element store and the shared step unit, and registers the result. Uses iira_pkg.
module iira_ctrl #(
  parameter int CAPACITY      = 64,
  parameter int ELEMENT_WIDTH = 32,
  localparam int AW   = $clog2(CAPACITY),
  localparam int CW   = $clog2(CAPACITY + 1)
) (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     start_i,
  output logic                     busy_o,
  input  iira_pkg::req_t           req_i,
  output logic                     done_o,
  output iira_pkg::rsp_t           rsp_o,
  output logic                     mem_we_o,
  output logic [AW-1:0]            mem_waddr_o,
  output logic [ELEMENT_WIDTH-1:0] mem_wdata_o,
  output logic                     mem_re_o,
  output logic [AW-1:0]            mem_raddr_o,
  input  logic [ELEMENT_WIDTH-1:0] mem_rdata_i,
  output logic [CW-1:0]            step_a_o,
  output logic [CW-1:0]            step_b_o,
  output logic                     step_dec_o,
  input  logic [CW-1:0]            step_res_i,
  input  logic                     step_eq_i,
  input  logic                     step_hit_i
);

  localparam int CMPW = (CW > iira_pkg::POS_W) ? CW : iira_pkg::POS_W;
  localparam int MW   = (ELEMENT_WIDTH > iira_pkg::VAL_W) ? ELEMENT_WIDTH : iira_pkg::VAL_W;

  iira_pkg::state_e         state_q, state_d;
  iira_pkg::kind_e          kind_q;
  logic [CMPW-1:0]          pos_q;
  logic [ELEMENT_WIDTH-1:0] val_q;
  logic [CW-1:0]            cnt_q, cnt_d;
  logic [CW-1:0]            ptr_q, ptr_d;
  logic [CW-1:0]            dst_q, dst_d;
  logic [ELEMENT_WIDTH-1:0] ret_q, ret_d;
  logic                     done_q, done_d;
  iira_pkg::rsp_t           rsp_q, rsp_d;

  logic [MW-1:0]            vin_ext;
  logic [MW-1:0]            rd_ext;
  logic [MW-1:0]            ret_ext;
  logic [CMPW-1:0]          cnt_ext;
  logic [CMPW-1:0]          cnt_d_ext;
  logic [CW-1:0]            pos_c;
  logic                     pos_lt, pos_le, not_full, not_empty;
  logic                     fin_err;
  logic [iira_pkg::VAL_W-1:0] fin_val;

  // fit the input value to the element width and elements back to the port
  assign vin_ext = MW'(req_i.value_in);
  assign rd_ext  = MW'(mem_rdata_i);
  assign ret_ext = MW'(ret_q);

  // bounds checks against the live count
  assign cnt_ext   = CMPW'(cnt_q);
  assign pos_c     = pos_q[CW-1:0];
  assign pos_lt    = (pos_q < cnt_ext);
  assign pos_le    = (pos_q <= cnt_ext);
  assign not_full  = (cnt_q != CW'(CAPACITY));
  assign not_empty = (cnt_q != '0);

  assign busy_o = (state_q != iira_pkg::ST_IDLE);

  // next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      iira_pkg::ST_IDLE: begin
        if (start_i) begin
          state_d = iira_pkg::ST_EXEC;
        end
      end
      iira_pkg::ST_EXEC: begin
        unique case (kind_q)
          iira_pkg::KIND_GET:
            state_d = pos_lt ? iira_pkg::ST_RDATA : iira_pkg::ST_IDLE;
          iira_pkg::KIND_POP:
            state_d = not_empty ? iira_pkg::ST_RDATA : iira_pkg::ST_IDLE;
          iira_pkg::KIND_INSERT: begin
            if (pos_le && not_full) begin
              state_d = pos_lt ? iira_pkg::ST_SHUP : iira_pkg::ST_INS_FIN;
            end else begin
              state_d = iira_pkg::ST_IDLE;
            end
          end
          iira_pkg::KIND_REMOVE:
            state_d = pos_lt ? iira_pkg::ST_RMV_GET : iira_pkg::ST_IDLE;
          default: state_d = iira_pkg::ST_IDLE;
        endcase
      end
      iira_pkg::ST_RDATA:   state_d = iira_pkg::ST_IDLE;
      iira_pkg::ST_SHUP: begin
        if (step_hit_i) begin
          state_d = iira_pkg::ST_INS_FIN;
        end
      end
      iira_pkg::ST_INS_FIN: state_d = iira_pkg::ST_IDLE;
      iira_pkg::ST_RMV_GET:
        state_d = step_eq_i ? iira_pkg::ST_RMV_FIN : iira_pkg::ST_SHDN;
      iira_pkg::ST_SHDN: begin
        if (step_eq_i) begin
          state_d = iira_pkg::ST_RMV_FIN;
        end
      end
      iira_pkg::ST_RMV_FIN: state_d = iira_pkg::ST_IDLE;
      default:              state_d = iira_pkg::ST_IDLE;
    endcase
  end

  // datapath controls per state
  always_comb begin
    mem_we_o    = 1'b0;
    mem_waddr_o = dst_q[AW-1:0];
    mem_wdata_o = mem_rdata_i;
    mem_re_o    = 1'b0;
    mem_raddr_o = step_res_i[AW-1:0];
    step_a_o    = cnt_q;
    step_b_o    = cnt_q;
    step_dec_o  = 1'b1;
    cnt_d       = cnt_q;
    ptr_d       = ptr_q;
    dst_d       = dst_q;
    ret_d       = ret_q;
    done_d      = 1'b0;
    fin_err     = 1'b1;
    fin_val     = '0;
    unique case (state_q)
      iira_pkg::ST_IDLE: begin
      end
      iira_pkg::ST_EXEC: begin
        unique case (kind_q)
          iira_pkg::KIND_GET: begin
            // fetch the entry; the read-data state answers with it
            mem_re_o    = pos_lt;
            mem_raddr_o = pos_c[AW-1:0];
            done_d      = !pos_lt;
          end
          iira_pkg::KIND_SET: begin
            mem_we_o    = pos_lt;
            mem_waddr_o = pos_c[AW-1:0];
            mem_wdata_o = val_q;
            done_d      = 1'b1;
            fin_err     = !pos_lt;
          end
          iira_pkg::KIND_PUSH: begin
            // write at the end and grow
            step_dec_o  = 1'b0;
            mem_we_o    = not_full;
            mem_waddr_o = cnt_q[AW-1:0];
            mem_wdata_o = val_q;
            done_d      = 1'b1;
            fin_err     = !not_full;
            if (not_full) begin
              cnt_d = step_res_i;
            end
          end
          iira_pkg::KIND_POP: begin
            // fetch the last entry at count minus one
            mem_re_o = not_empty;
            done_d   = !not_empty;
          end
          iira_pkg::KIND_INSERT: begin
            if (pos_le && not_full) begin
              // start the upward shift from the top entry
              mem_re_o = pos_lt;
              ptr_d    = step_res_i;
              dst_d    = cnt_q;
            end else begin
              done_d = 1'b1;
            end
          end
          iira_pkg::KIND_REMOVE: begin
            mem_re_o    = pos_lt;
            mem_raddr_o = pos_c[AW-1:0];
            ptr_d       = pos_c;
            done_d      = !pos_lt;
          end
          iira_pkg::KIND_CLEAR: begin
            cnt_d   = '0;
            done_d  = 1'b1;
            fin_err = 1'b0;
          end
          default: begin
            done_d = 1'b1;
          end
        endcase
      end
      iira_pkg::ST_RDATA: begin
        // answer get or pop with the fetched entry; pop also shrinks the count
        done_d  = 1'b1;
        fin_err = 1'b0;
        fin_val = rd_ext[iira_pkg::VAL_W-1:0];
        if (kind_q == iira_pkg::KIND_POP) begin
          cnt_d = step_res_i;
        end
      end
      iira_pkg::ST_SHUP: begin
        // move one entry up, fetch the one below it
        step_a_o = ptr_q;
        step_b_o = pos_c;
        mem_we_o = 1'b1;
        if (!step_hit_i) begin
          mem_re_o = 1'b1;
          ptr_d    = step_res_i;
          dst_d    = ptr_q;
        end
      end
      iira_pkg::ST_INS_FIN: begin
        // place the new entry and grow
        step_dec_o  = 1'b0;
        mem_we_o    = 1'b1;
        mem_waddr_o = pos_c[AW-1:0];
        mem_wdata_o = val_q;
        cnt_d       = step_res_i;
        done_d      = 1'b1;
        fin_err     = 1'b0;
      end
      iira_pkg::ST_RMV_GET: begin
        // hold the removed entry, fetch its upper neighbor
        ret_d      = mem_rdata_i;
        step_a_o   = ptr_q;
        step_dec_o = 1'b0;
        if (!step_eq_i) begin
          mem_re_o = 1'b1;
          ptr_d    = step_res_i;
          dst_d    = ptr_q;
        end
      end
      iira_pkg::ST_SHDN: begin
        // move one entry down, fetch the next one up
        step_a_o   = ptr_q;
        step_dec_o = 1'b0;
        mem_we_o   = 1'b1;
        if (!step_eq_i) begin
          mem_re_o = 1'b1;
          ptr_d    = step_res_i;
          dst_d    = ptr_q;
        end
      end
      iira_pkg::ST_RMV_FIN: begin
        // shrink and answer with the removed entry
        cnt_d   = step_res_i;
        done_d  = 1'b1;
        fin_err = 1'b0;
        fin_val = ret_ext[iira_pkg::VAL_W-1:0];
      end
      default: begin
      end
    endcase
  end

  // assemble the result
  assign cnt_d_ext       = CMPW'(cnt_d);
  assign rsp_d.status    = fin_err;
  assign rsp_d.value_out = fin_val;
  assign rsp_d.count     = cnt_d_ext[iira_pkg::CNT_OUT_W-1:0];

  // control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= iira_pkg::ST_IDLE;
      cnt_q   <= '0;
      done_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      cnt_q   <= cnt_d;
      done_q  <= done_d;
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    if (state_q == iira_pkg::ST_IDLE && start_i) begin
      kind_q <= iira_pkg::kind_e'(req_i.kind);
      pos_q  <= CMPW'(req_i.position);
      val_q  <= vin_ext[ELEMENT_WIDTH-1:0];
    end
    ptr_q <= ptr_d;
    dst_q <= dst_d;
    ret_q <= ret_d;
    if (done_d) begin
      rsp_q <= rsp_d;
    end
  end

  assign done_o = done_q;
  assign rsp_o  = rsp_q;

endmodule

>>> rtl/iira_chk.sv
// Port-level checker for the indexed insert/remove array core, with its bind.
// Uses iira_pkg.
module iira_chk (
  input logic           clk_i,
  input logic           rst_ni,
  input logic           start,
  input logic           busy,
  input iira_pkg::req_t req_i,
  input logic           done_o,
  input iira_pkg::rsp_t rsp_o
);

  // an accepted item keeps the block busy next cycle
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start && !busy) |=> busy)
    else $error("item accepted but block not busy");

  // a result only follows a busy cycle
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> $past(busy))
    else $error("result without a running item");

  // results never come on back-to-back cycles
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |=> !done_o)
    else $error("two results in consecutive cycles");

  // an error result carries a zero value
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (done_o && rsp_o.status) |-> (rsp_o.value_out == '0))
    else $error("error result with nonzero value");

endmodule

bind indexed_insert_remove_array_core iira_chk u_chk (
  .clk_i  (clk_i),
  .rst_ni (rst_ni),
  .start  (start),
  .busy   (busy),
  .req_i  (req_i),
  .done_o (done_o),
  .rsp_o  (rsp_o)
);
